@@ rtl/core/rsi_pkg.sv @@
// Shared widths, field offsets, register indexes and reset values for the
// relative strength index block. No dependencies.
`timescale 1ns / 1ps

package rsi_pkg;

    localparam int PRICE_W    = 32;
    localparam int PRICE_BITS = 32;
    localparam int AVG_W      = 48;
    localparam int FRAC_BITS  = 16;
    localparam int PERIOD_W   = 8;
    localparam int LEVEL_W    = 15;
    localparam int RSI_W      = 15;
    localparam int ZONE_W     = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 15;

    localparam int SUM_W      = AVG_W + 1;
    localparam int RSI_PROD_W = AVG_W + 5;
    localparam int RSI_SHIFT  = 10;
    localparam int RSI_PRE    = RSI_W - RSI_SHIFT;

    localparam int NDIV_W     = AVG_W + PERIOD_W + 2;
    localparam int NDIV_STEPS = NDIV_W / 2;
    localparam int STEP_W     = $clog2(NDIV_STEPS);
    localparam int SEED_W     = NDIV_W - FRAC_BITS;

    localparam int RSI_LSB    = 0;
    localparam int ZONE_LSB   = RSI_LSB + RSI_W;
    localparam int GAIN_LSB   = ZONE_LSB + ZONE_W;
    localparam int LOSS_LSB   = GAIN_LSB + AVG_W;
    localparam int FIELD_BITS = LOSS_LSB + AVG_W;
    localparam int TDATA_W    = ((FIELD_BITS + 7) / 8) * 8;

    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OVERBOUGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_OVERSOLD   = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd14;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 8'd2;
    localparam logic [LEVEL_W-1:0]  OB_RESET     = 15'd17920;
    localparam logic [LEVEL_W-1:0]  OS_RESET     = 15'd7680;
    localparam logic [RSI_W-1:0]    RSI_HALF     = 15'd12800;
    localparam logic [RSI_W-1:0]    RSI_FULL     = 15'd25600;

    localparam logic [ZONE_W-1:0] ZONE_NEUTRAL    = 2'd0;
    localparam logic [ZONE_W-1:0] ZONE_OVERBOUGHT = 2'd1;
    localparam logic [ZONE_W-1:0] ZONE_OVERSOLD   = 2'd2;

    typedef struct packed {
        logic [PERIOD_W-1:0] rem;
        logic [1:0]          q;
    } ndiv_step_t;

endpackage

@@ rtl/core/relative_strength_index_top.sv @@
// Relative strength index with smoothed average gain and loss.
// Depends on rsi_pkg for widths, field offsets and register codes.
//
//   channel   direction  handshake           content
//   s_        in         s_tvalid/s_tready   tdata: price[31:0]
//   m_        out        m_tvalid/m_tready   tdata: rsi_value, zone, average_gain,
//                                            average_loss; tuser: rsi_valid
//   cfg_      in         cfg_we              cfg_addr selects the register
//
// The first price after reset goes straight to the output register; a warm-up beat adds
// the price change to the running sums first. A beat that seeds or smooths the averages
// runs two narrow dividers by the period, which retire two quotient bits per cycle, then
// the index divider, which retires one bit per cycle; when both averages are zero that
// divider is skipped. A finished result waits while the output register is still full;
// once it is loaded the next beat is taken. Reset is synchronous and active low.
`timescale 1ns / 1ps

module relative_strength_index_top
    import rsi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PRICE_W-1:0]    s_tdata,   // price[31:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // rsi_value, zone, average_gain, average_loss
    output logic                  m_tuser,   // rsi_valid
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_NDIV = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_RDIV = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    function automatic ndiv_step_t ndiv_step(input logic [PERIOD_W-1:0] rem,
                                             input logic [1:0] bits,
                                             input logic [PERIOD_W-1:0] d);
        logic [PERIOD_W:0] t1;
        logic [PERIOD_W:0] t2;
        ndiv_step_t        res;
        t1 = {rem, bits[1]};
        res.q = 2'b00;
        if (t1 >= {1'b0, d}) begin
            t1 = t1 - {1'b0, d};
            res.q[1] = 1'b1;
        end
        t2 = {t1[PERIOD_W-1:0], bits[0]};
        if (t2 >= {1'b0, d}) begin
            t2 = t2 - {1'b0, d};
            res.q[0] = 1'b1;
        end
        res.rem = t2[PERIOD_W-1:0];
        return res;
    endfunction

    function automatic logic [AVG_W-1:0] sat_quot(input logic [NDIV_W-1:0] q);
        if (|q[NDIV_W-1:AVG_W]) begin
            return '1;
        end
        return q[AVG_W-1:0];
    endfunction

    function automatic logic [AVG_W-1:0] sat_add(input logic [AVG_W-1:0] a,
                                                 input logic [PRICE_BITS-1:0] b);
        logic [SUM_W-1:0] s;
        s = {1'b0, a} + SUM_W'(b);
        if (s[AVG_W]) begin
            return '1;
        end
        return s[AVG_W-1:0];
    endfunction

    logic [2:0]            state_reg, state_next;
    logic [PERIOD_W-1:0]   period_reg, period_next;
    logic [LEVEL_W-1:0]    ob_reg, ob_next;
    logic [LEVEL_W-1:0]    os_reg, os_next;
    logic [PRICE_BITS-1:0] prev_reg, prev_next;
    logic                  have_prev_reg, have_prev_next;
    logic [PERIOD_W-1:0]   count_reg, count_next;
    logic [AVG_W-1:0]      avg_g_reg, avg_g_next;
    logic [AVG_W-1:0]      avg_l_reg, avg_l_next;
    logic                  smooth_reg, smooth_next;
    logic                  res_valid_reg, res_valid_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    logic [PRICE_BITS-1:0] gain_reg, gain_next;
    logic [PRICE_BITS-1:0] loss_reg, loss_next;
    logic [NDIV_W-1:0]     dvd_g_reg, dvd_g_next;
    logic [NDIV_W-1:0]     dvd_l_reg, dvd_l_next;
    logic [PERIOD_W-1:0]   rem_g_reg, rem_g_next;
    logic [PERIOD_W-1:0]   rem_l_reg, rem_l_next;
    logic [SUM_W-1:0]      total_reg, total_next;
    logic [SUM_W-1:0]      rrem_reg, rrem_next;
    logic [RSI_W-1:0]      rq_reg, rq_next;
    logic [TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;

    logic [PRICE_BITS-1:0]        price_c;
    logic [PERIOD_W-1:0]          n_c;
    logic [PERIOD_W-1:0]          nm1_c;
    logic [AVG_W+PERIOD_W-1:0]    prod_g_c;
    logic [AVG_W+PERIOD_W-1:0]    prod_l_c;
    logic [RSI_PROD_W-1:0]        g25_c;
    logic [SUM_W:0]               rt_c;
    logic [SUM_W:0]               rsub_c;
    logic [ZONE_W-1:0]            zone_c;
    ndiv_step_t                   step_g_c;
    ndiv_step_t                   step_l_c;
    logic [NDIV_W-1:0]            qg_c;
    logic [NDIV_W-1:0]            ql_c;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        price_c  = s_tdata[PRICE_BITS-1:0];
        n_c      = (period_reg < PERIOD_MIN) ? PERIOD_MIN : period_reg;
        nm1_c    = n_c - PERIOD_W'(1);
        prod_g_c = avg_g_reg * nm1_c;
        prod_l_c = avg_l_reg * nm1_c;
        g25_c    = (RSI_PROD_W'(avg_g_reg) << 4) + (RSI_PROD_W'(avg_g_reg) << 3)
                 + RSI_PROD_W'(avg_g_reg);
        rt_c     = {rrem_reg, rq_reg[RSI_W-1]};
        rsub_c   = rt_c - {1'b0, total_reg};
        step_g_c = ndiv_step(rem_g_reg, dvd_g_reg[NDIV_W-1 -: 2], n_c);
        step_l_c = ndiv_step(rem_l_reg, dvd_l_reg[NDIV_W-1 -: 2], n_c);
        qg_c     = {dvd_g_reg[NDIV_W-3:0], step_g_c.q};
        ql_c     = {dvd_l_reg[NDIV_W-3:0], step_l_c.q};

        if (rq_reg >= ob_reg) begin
            zone_c = ZONE_OVERBOUGHT;
        end else if (rq_reg <= os_reg) begin
            zone_c = ZONE_OVERSOLD;
        end else begin
            zone_c = ZONE_NEUTRAL;
        end
    end

    always_comb begin
        state_next     = state_reg;
        period_next    = period_reg;
        ob_next        = ob_reg;
        os_next        = os_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        count_next     = count_reg;
        avg_g_next     = avg_g_reg;
        avg_l_next     = avg_l_reg;
        smooth_next    = smooth_reg;
        res_valid_next = res_valid_reg;
        step_next      = step_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        gain_next      = gain_reg;
        loss_next      = loss_reg;
        dvd_g_next     = dvd_g_reg;
        dvd_l_next     = dvd_l_reg;
        rem_g_next     = rem_g_reg;
        rem_l_next     = rem_l_reg;
        total_next     = total_reg;
        rrem_next      = rrem_reg;
        rq_next        = rq_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (price_c > prev_reg) begin
                        gain_next = price_c - prev_reg;
                        loss_next = '0;
                    end else begin
                        gain_next = '0;
                        loss_next = prev_reg - price_c;
                    end
                    prev_next      = price_c;
                    have_prev_next = 1'b1;
                    res_valid_next = 1'b0;
                    state_next     = have_prev_reg ? ST_MUL : ST_OUT;
                end
            end
            ST_MUL: begin
                smooth_next = (count_reg >= n_c);
                if (count_reg >= n_c) begin
                    dvd_g_next = NDIV_W'(prod_g_c);
                    dvd_l_next = NDIV_W'(prod_l_c);
                end else begin
                    avg_g_next = sat_add(avg_g_reg, gain_reg);
                    avg_l_next = sat_add(avg_l_reg, loss_reg);
                    count_next = count_reg + PERIOD_W'(1);
                end
                state_next = ST_ADD;
            end
            ST_ADD: begin
                rem_g_next = '0;
                rem_l_next = '0;
                step_next  = '0;
                if (smooth_reg) begin
                    dvd_g_next = dvd_g_reg + NDIV_W'({gain_reg, FRAC_BITS'(0)});
                    dvd_l_next = dvd_l_reg + NDIV_W'({loss_reg, FRAC_BITS'(0)});
                    state_next = ST_NDIV;
                end else if (count_reg >= n_c) begin
                    dvd_g_next = {avg_g_reg[SEED_W-1:0], FRAC_BITS'(0)};
                    dvd_l_next = {avg_l_reg[SEED_W-1:0], FRAC_BITS'(0)};
                    state_next = ST_NDIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_NDIV: begin
                dvd_g_next = qg_c;
                dvd_l_next = ql_c;
                rem_g_next = step_g_c.rem;
                rem_l_next = step_l_c.rem;
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(NDIV_STEPS - 1)) begin
                    avg_g_next     = sat_quot(qg_c);
                    avg_l_next     = sat_quot(ql_c);
                    res_valid_next = 1'b1;
                    state_next     = ST_SUM;
                end
            end
            ST_SUM: begin
                total_next = SUM_W'(avg_g_reg) + SUM_W'(avg_l_reg);
                rrem_next  = SUM_W'(g25_c[RSI_PROD_W-1:RSI_PRE]);
                rq_next    = {g25_c[RSI_PRE-1:0], RSI_SHIFT'(0)};
                step_next  = '0;
                if ((avg_g_reg == '0) && (avg_l_reg == '0)) begin
                    rq_next    = RSI_HALF;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_RDIV;
                end
            end
            ST_RDIV: begin
                if (rt_c >= {1'b0, total_reg}) begin
                    rrem_next = rsub_c[SUM_W-1:0];
                    rq_next   = {rq_reg[RSI_W-2:0], 1'b1};
                end else begin
                    rrem_next = rt_c[SUM_W-1:0];
                    rq_next   = {rq_reg[RSI_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(RSI_W - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next = '0;
                    if (res_valid_reg) begin
                        m_tdata_next[RSI_LSB +: RSI_W]   = rq_reg;
                        m_tdata_next[ZONE_LSB +: ZONE_W] = zone_c;
                        m_tdata_next[GAIN_LSB +: AVG_W]  = avg_g_reg;
                        m_tdata_next[LOSS_LSB +: AVG_W]  = avg_l_reg;
                    end
                    m_tuser_next  = res_valid_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we) begin
            case (cfg_addr)
                REG_PERIOD: begin
                    period_next = cfg_wdata[PERIOD_W-1:0];
                    count_next  = '0;
                    avg_g_next  = '0;
                    avg_l_next  = '0;
                end
                REG_OVERBOUGHT: begin
                    ob_next = cfg_wdata[LEVEL_W-1:0];
                end
                REG_OVERSOLD: begin
                    os_next = cfg_wdata[LEVEL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            period_reg    <= PERIOD_RESET;
            ob_reg        <= OB_RESET;
            os_reg        <= OS_RESET;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            count_reg     <= '0;
            avg_g_reg     <= '0;
            avg_l_reg     <= '0;
            smooth_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
            step_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            period_reg    <= period_next;
            ob_reg        <= ob_next;
            os_reg        <= os_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            count_reg     <= count_next;
            avg_g_reg     <= avg_g_next;
            avg_l_reg     <= avg_l_next;
            smooth_reg    <= smooth_next;
            res_valid_reg <= res_valid_next;
            step_reg      <= step_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        gain_reg    <= gain_next;
        loss_reg    <= loss_next;
        dvd_g_reg   <= dvd_g_next;
        dvd_l_reg   <= dvd_l_next;
        rem_g_reg   <= rem_g_next;
        rem_l_reg   <= rem_l_next;
        total_reg   <= total_next;
        rrem_reg    <= rrem_next;
        rq_reg      <= rq_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

@@ rtl/core/rsi_checker.sv @@
// Port-level checks for the relative strength index top level, and the bind
// that attaches them. Depends on rsi_pkg and relative_strength_index_top.
`timescale 1ns / 1ps

module rsi_checker
    import rsi_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [TDATA_W-1:0]    m_tdata,
    input logic                  m_tuser
);

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // The block works on one price at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after a beat");

    // During warm-up every result field reads as zero.
    a_warm_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("warm-up beat carries nonzero fields");

    // A seeded result stays within full scale and uses a defined zone.
    a_rsi_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[RSI_LSB +: RSI_W] <= RSI_FULL)
            && (m_tdata[ZONE_LSB +: ZONE_W] != 2'd3))
        else $error("index or zone out of range");

endmodule

bind relative_strength_index_top rsi_checker u_rsi_checker (.*);

@@ sim/tb_relative_strength_index_top.sv @@
// Self-checking testbench for relative_strength_index_top: drives price beats,
// predicts every result beat internally and compares it field by field.
// Depends on rsi_pkg and the relative_strength_index_top RTL only.
`timescale 1ns / 1ps

module tb_relative_strength_index_top;
    import rsi_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [63:0] AVG_CAP    = (64'd1 << AVG_W) - 64'd1;
    localparam logic [63:0] SCALE_CAP  = AVG_CAP >> FRAC_BITS;
    localparam int          DRAIN_WAIT = 64;
    localparam int          CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [RSI_W-1:0]  rsi;
        logic              valid;
        logic [ZONE_W-1:0] zone;
        logic [AVG_W-1:0]  gain;
        logic [AVG_W-1:0]  loss;
    } rsi_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PRICE_W-1:0]    s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tuser;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    logic [PERIOD_W-1:0] period_reg;
    logic [LEVEL_W-1:0]  overbought_reg;
    logic [LEVEL_W-1:0]  oversold_reg;
    logic [31:0]         last_price;
    logic                have_last;
    logic [7:0]          changes_seen;
    logic [63:0]         gain_avg;
    logic [63:0]         loss_avg;

    rsi_result_t expected_rsi[$];
    rsi_result_t want;
    rsi_result_t got;
    int          fail_count;
    int          cycle_count;
    bit          no_idle;
    logic [31:0] walk_price;

    relative_strength_index_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [63:0] clamp_avg(input logic [63:0] value);
        return (value > AVG_CAP) ? AVG_CAP : value;
    endfunction

    function automatic logic [63:0] to_fraction(input logic [63:0] part);
        return (part > SCALE_CAP) ? AVG_CAP : (part << FRAC_BITS);
    endfunction

    function automatic logic [63:0] seed_average(input logic [63:0] sum,
                                                 input logic [63:0] n);
        logic [63:0] quot;
        logic [63:0] rem;
        quot = sum / n;
        rem  = sum % n;
        if (quot > SCALE_CAP) begin
            return AVG_CAP;
        end
        return clamp_avg((quot << FRAC_BITS) + ((rem << FRAC_BITS) / n));
    endfunction

    function automatic logic [63:0] smooth_average(input logic [63:0] avg,
                                                   input logic [63:0] part,
                                                   input logic [63:0] n);
        return clamp_avg((avg * (n - 64'd1) + to_fraction(part)) / n);
    endfunction

    function automatic void apply_register(input logic [CFG_ADDR_W-1:0] addr,
                                           input logic [CFG_DATA_W-1:0] data);
        case (addr)
            REG_PERIOD: begin
                period_reg   = data[PERIOD_W-1:0];
                changes_seen = '0;
                gain_avg     = '0;
                loss_avg     = '0;
            end
            REG_OVERBOUGHT: begin
                overbought_reg = data[LEVEL_W-1:0];
            end
            REG_OVERSOLD: begin
                oversold_reg = data[LEVEL_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    function automatic rsi_result_t predict_rsi(input logic [31:0] price);
        rsi_result_t res;
        logic [63:0] n;
        logic [63:0] up;
        logic [63:0] down;
        logic [63:0] total;
        logic [63:0] ratio;
        res  = '0;
        up   = '0;
        down = '0;
        n    = (period_reg < PERIOD_MIN) ? 64'(PERIOD_MIN) : 64'(period_reg);
        if (have_last) begin
            if (price > last_price) begin
                up = 64'(price - last_price);
            end else begin
                down = 64'(last_price - price);
            end
            if (64'(changes_seen) >= n) begin
                gain_avg = smooth_average(gain_avg, up, n);
                loss_avg = smooth_average(loss_avg, down, n);
            end else begin
                gain_avg     = clamp_avg(gain_avg + up);
                loss_avg     = clamp_avg(loss_avg + down);
                changes_seen = changes_seen + 8'd1;
                if (64'(changes_seen) >= n) begin
                    gain_avg = seed_average(gain_avg, n);
                    loss_avg = seed_average(loss_avg, n);
                end
            end
            res.valid = (64'(changes_seen) >= n);
        end
        last_price = price;
        have_last  = 1'b1;
        if (res.valid) begin
            total = gain_avg + loss_avg;
            ratio = (total == 0) ? 64'(RSI_HALF) : (gain_avg * 64'(RSI_FULL)) / total;
            res.rsi = ratio[RSI_W-1:0];
            if (ratio >= 64'(overbought_reg)) begin
                res.zone = ZONE_OVERBOUGHT;
            end else if (ratio <= 64'(oversold_reg)) begin
                res.zone = ZONE_OVERSOLD;
            end else begin
                res.zone = ZONE_NEUTRAL;
            end
            res.gain = gain_avg[AVG_W-1:0];
            res.loss = loss_avg[AVG_W-1:0];
        end
        return res;
    endfunction

    task automatic send_price(input logic [31:0] price);
        @(negedge aclk);
        while (!no_idle && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= price;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        expected_rsi.push_back(predict_rsi(price));
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_rsi.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        apply_register(addr, data);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 8);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_rsi.size() == 0) begin
                $error("result beat with no expected result");
                fail_count++;
            end else begin
                want      = expected_rsi.pop_front();
                got.rsi   = m_tdata[RSI_LSB +: RSI_W];
                got.valid = m_tuser;
                got.zone  = m_tdata[ZONE_LSB +: ZONE_W];
                got.gain  = m_tdata[GAIN_LSB +: AVG_W];
                got.loss  = m_tdata[LOSS_LSB +: AVG_W];
                check_field("rsi_value", 64'(want.rsi), 64'(got.rsi));
                check_field("rsi_valid", 64'(want.valid), 64'(got.valid));
                check_field("zone", 64'(want.zone), 64'(got.zone));
                check_field("average_gain", 64'(want.gain), 64'(got.gain));
                check_field("average_loss", 64'(want.loss), 64'(got.loss));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Period values 0 and 1 behave as 2; covers the price extremes and a flat market.
    task automatic test_period_floor();
        write_reg(REG_PERIOD, 15'd0);
        send_price(32'h0000_0000);
        send_price(32'hFFFF_FFFF);
        send_price(32'hFFFF_FFFF);
        send_price(32'h0000_0000);
        send_price(32'h0000_0000);
        wait_idle();
        write_reg(REG_PERIOD, 15'd1);
        send_price(32'd5);
        send_price(32'd5);
        send_price(32'd5);
        send_price(32'hFFFF_FFFF);
    endtask

    // Overlapping levels must report overbought; levels above full scale are honored.
    task automatic test_thresholds();
        wait_idle();
        write_reg(REG_PERIOD, 15'd2);
        write_reg(REG_OVERBOUGHT, 15'd12800);
        write_reg(REG_OVERSOLD, 15'd12800);
        send_price(32'd7);
        send_price(32'd7);
        send_price(32'd7);
        wait_idle();
        write_reg(REG_OVERBOUGHT, 15'h7FFF);
        write_reg(REG_OVERSOLD, 15'd0);
        write_reg(REG_UNUSED, 15'h5A5A);
        send_price(32'd8);
        send_price(32'd1);
        send_price(32'd0);
    endtask

    // Rewriting the period clears the warm-up but keeps the last price.
    task automatic test_period_rewrite();
        wait_idle();
        write_reg(REG_PERIOD, 15'h7F03);
        send_price(32'd100);
        send_price(32'd300);
        wait_idle();
        write_reg(REG_PERIOD, 15'd3);
        send_price(32'd200);
        send_price(32'd250);
        send_price(32'd150);
        send_price(32'd400);
    endtask

    task automatic test_random_prices(input int items, input logic [PERIOD_W-1:0] period,
                                      input logic [LEVEL_W-1:0] ob_level,
                                      input logic [LEVEL_W-1:0] os_level,
                                      input bit steady);
        int roll;
        int drift;
        wait_idle();
        write_reg(REG_OVERBOUGHT, ob_level);
        write_reg(REG_OVERSOLD, os_level);
        write_reg(REG_PERIOD, 15'(period));
        no_idle = steady;
        drift   = 0;
        for (int i = 0; i < items; i++) begin
            if (i % 16 == 0) begin
                drift = $urandom_range(0, 600) - 300;
            end
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                walk_price = $urandom();
            end else if (roll < 10) begin
                walk_price = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
            end else if (roll >= 16) begin
                walk_price = walk_price + 32'(drift) + 32'($urandom_range(0, 2000)) - 32'd1000;
            end
            send_price(walk_price);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = REG_PERIOD;
        cfg_wdata      = '0;
        no_idle        = 1'b0;
        fail_count     = 0;
        cycle_count    = 0;
        walk_price     = 32'd1_000_000;
        period_reg     = PERIOD_RESET;
        overbought_reg = OB_RESET;
        oversold_reg   = OS_RESET;
        last_price     = '0;
        have_last      = 1'b0;
        changes_seen   = '0;
        gain_avg       = '0;
        loss_avg       = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        test_period_floor();
        test_thresholds();
        test_period_rewrite();
        test_random_prices(80, PERIOD_RESET, OB_RESET, OS_RESET, 1'b1);
        test_random_prices(60, PERIOD_MIN, RSI_FULL, 15'd0, 1'b0);
        test_random_prices(270, 8'd255, 15'd0, RSI_FULL, 1'b0);
        test_random_prices(80, 8'($urandom_range(3, 40)), 15'($urandom_range(12800, 25600)),
                           15'($urandom_range(0, 12800)), 1'b0);
        wait_idle();

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
